// ===== rtl/htd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Shared widths, action codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int IDX_W      = 9;
  localparam int COUNT_W    = 24;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_NODE_COUNT  = 512;
  localparam int DEF_SYMBOL_BITS = 8;

  // Most significant bit of a data byte, which is consumed first.
  localparam logic [BIT_IDX_W-1:0] TOP_BIT = 3'd7;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_DATA    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX   = 1'b1;

endpackage

// ===== rtl/htd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/huffman_tree_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder core
// Walks a code tree held in a node RAM, one bit of a data byte at a time.
// ----------------------------------------------------------------------------
// Load-node and restart beats are taken while idle. A data byte keeps the
// input stalled while the walk evaluates each bit (a child read after the
// parent step, or a single step when the walk stands on a leaf) and a flush
// step closes the byte; a completed message ends it early and output stalls
// hold it longer. Every bit needs a dependent node RAM read. Reset clears
// the state, the configuration registers, the valid flags, the count and the
// walk (back to node 0); the node table is not cleared.
module huffman_tree_decoder_core #(
  parameter int NODE_COUNT  = htd_pkg::DEF_NODE_COUNT,
  parameter int SYMBOL_BITS = htd_pkg::DEF_SYMBOL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [htd_pkg::IDX_W-1:0]       node_index,
  input  logic                            node_is_leaf,
  input  logic [SYMBOL_BITS-1:0]          node_symbol,
  input  logic [htd_pkg::IDX_W-1:0]       node_left,
  input  logic [htd_pkg::IDX_W-1:0]       node_right,
  input  logic [htd_pkg::BYTE_W-1:0]      data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SYMBOL_BITS-1:0]          symbol,
  output logic                            last,
  output logic                            message_done,
  input  logic                            cfg_write,
  input  logic [htd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import htd_pkg::*;

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int ENT_W  = 1 + SYMBOL_BITS + 2 * IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_NX,
    ST_FLUSH
  } state_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic in_table(input logic [IDX_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  function automatic logic ent_leaf(input logic [ENT_W-1:0] e);
    return e[ENT_W-1];
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] ent_sym(input logic [ENT_W-1:0] e);
    return e[ENT_W-2 -: SYMBOL_BITS];
  endfunction

  // Registers
  state_t                state, state_next;
  logic [COUNT_W-1:0]    symbol_total;
  logic [IDX_W-1:0]      root_index;
  logic [IDX_W-1:0]      cur_node, cur_node_next;
  logic [COUNT_W-1:0]    count, count_next;
  logic [BIT_IDX_W-1:0]  bit_idx, bit_idx_next;
  logic [BYTE_W-1:0]     byte_reg, byte_reg_next;
  logic [IDX_W-1:0]      child_idx, child_idx_next;
  logic [ENT_W-1:0]      cur_ent, cur_ent_next;
  logic                  use_ram, use_ram_next;
  logic                  rd_oor, rd_oor_next;
  logic                  pend_valid, pend_valid_next;
  logic [SYMBOL_BITS-1:0] pend_sym, pend_sym_next;
  logic                  pend_done, pend_done_next;

  // RAM interface
  logic                  ram_we;
  logic                  ram_re;
  logic [IDX_W-1:0]      rd_idx;
  logic [ENT_W-1:0]      ram_wdata;
  logic [ENT_W-1:0]      ram_rdata;

  // Datapath
  logic [ENT_W-1:0]      rd_ent;
  logic [ENT_W-1:0]      ent;
  logic [IDX_W-1:0]      child;
  logic                  out_free;
  logic                  emit_req;
  logic [SYMBOL_BITS-1:0] emit_sym;
  logic                  push;
  logic [SYMBOL_BITS-1:0] push_sym;
  logic                  push_last;
  logic                  push_done;
  logic [COUNT_W-1:0]    count_inc;

  htd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT),
    .AW    (ADDR_W)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (to_addr(node_index)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (to_addr(rd_idx)),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {node_is_leaf, node_symbol, node_left, node_right};
  assign in_stall  = (state != ST_IDLE);

  // A child or root index past the end of the table reads as an all-zero node.
  assign rd_ent    = rd_oor ? '0 : ram_rdata;
  assign ent       = use_ram ? rd_ent : cur_ent;
  assign child     = byte_reg[bit_idx] ? ent[IDX_W-1:0] : ent[2*IDX_W-1:IDX_W];
  assign out_free  = !out_valid || !out_stall;
  assign count_inc = count + COUNT_W'(1);

  always_comb begin
    state_next      = state;
    cur_node_next   = cur_node;
    count_next      = count;
    bit_idx_next    = bit_idx;
    byte_reg_next   = byte_reg;
    child_idx_next  = child_idx;
    cur_ent_next    = cur_ent;
    use_ram_next    = use_ram;
    rd_oor_next     = rd_oor;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_done_next  = pend_done;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    rd_idx          = cur_node;
    emit_req        = 1'b0;
    emit_sym        = '0;
    push            = 1'b0;
    push_sym        = pend_sym;
    push_last       = 1'b0;
    push_done       = pend_done;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_LOAD: begin
              ram_we = in_table(node_index);
            end
            ACT_DATA: begin
              ram_re        = 1'b1;
              rd_idx        = cur_node;
              rd_oor_next   = !in_table(cur_node);
              use_ram_next  = 1'b1;
              byte_reg_next = data_byte;
              bit_idx_next  = TOP_BIT;
              state_next    = ST_CUR;
            end
            ACT_RESTART: begin
              cur_node_next = root_index;
              count_next    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CUR: begin
        if (count >= symbol_total) begin
          state_next = ST_FLUSH;
        end else if (ent_leaf(ent)) begin
          emit_req = 1'b1;
          emit_sym = ent_sym(ent);
        end else begin
          ram_re         = 1'b1;
          rd_idx         = child;
          rd_oor_next    = !in_table(child);
          child_idx_next = child;
          state_next     = ST_NX;
        end
      end
      ST_NX: begin
        if (ent_leaf(rd_ent)) begin
          emit_req = 1'b1;
          emit_sym = ent_sym(rd_ent);
        end else begin
          // Step down into the child; its contents are already in hand.
          cur_node_next = child_idx;
          cur_ent_next  = rd_ent;
          use_ram_next  = 1'b0;
          if (bit_idx == '0) begin
            state_next = ST_FLUSH;
          end else begin
            bit_idx_next = bit_idx - BIT_IDX_W'(1);
            state_next   = ST_CUR;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // A new symbol is held back one step so that the last one of a byte can
    // be marked; the previous one leaves for the output register now.
    if (emit_req && (!pend_valid || out_free)) begin
      push            = pend_valid;
      pend_valid_next = 1'b1;
      pend_sym_next   = emit_sym;
      pend_done_next  = (count_inc == symbol_total);
      count_next      = count_inc;
      cur_node_next   = root_index;
      ram_re          = 1'b1;
      rd_idx          = root_index;
      rd_oor_next     = !in_table(root_index);
      use_ram_next    = 1'b1;
      if (bit_idx == '0) begin
        state_next = ST_FLUSH;
      end else begin
        bit_idx_next = bit_idx - BIT_IDX_W'(1);
        state_next   = ST_CUR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      symbol_total <= '0;
      root_index   <= '0;
      cur_node     <= '0;
      count        <= '0;
      bit_idx      <= '0;
      use_ram      <= 1'b0;
      rd_oor       <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      cur_node   <= cur_node_next;
      count      <= count_next;
      bit_idx    <= bit_idx_next;
      use_ram    <= use_ram_next;
      rd_oor     <= rd_oor_next;
      pend_valid <= pend_valid_next;
      byte_reg   <= byte_reg_next;
      child_idx  <= child_idx_next;
      cur_ent    <= cur_ent_next;
      pend_sym   <= pend_sym_next;
      pend_done  <= pend_done_next;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SYMBOL_TOTAL: symbol_total <= cfg_data[COUNT_W-1:0];
          CFG_ROOT_INDEX:   root_index   <= cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end

      if (push) begin
        out_valid    <= 1'b1;
        symbol       <= push_sym;
        last         <= push_last;
        message_done <= push_done;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // No symbol may be left behind once a byte is finished.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending symbol left over in idle");

  // The child step always follows the evaluation of its parent, or holds while the output is stalled.
  a_nx_after_cur: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NX) |-> ($past(state) == ST_CUR || $past(state) == ST_NX))
    else $error("child step without parent evaluation");

  // Completing the message ends the byte, so that beat closes it.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_done) |-> last)
    else $error("message_done beat not marked last");
`endif

endmodule

// ===== bench/tb_huffman_tree_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree decoder core testbench
// Loads code trees into the node table, streams compressed bytes through the
// decoder and checks every symbol beat against an in-bench tree walk, with
// random idle bursts on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder_core;
  import htd_pkg::*;

  localparam int SYM_W         = DEF_SYMBOL_BITS;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_TARGET   = 370;
  localparam int CALM_TAIL     = 310;
  localparam int MAX_REPORTS   = 10;

  localparam logic [1:0]         ACT_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] TOTAL_MAX  = '1;
  localparam logic [IDX_W-1:0]   INDEX_MAX  = '1;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done;
  } symbol_beat_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            action       = ACT_LOAD;
  logic [IDX_W-1:0]      node_index   = '0;
  logic                  node_is_leaf = 1'b0;
  logic [SYM_W-1:0]      node_symbol  = '0;
  logic [IDX_W-1:0]      node_left    = '0;
  logic [IDX_W-1:0]      node_right   = '0;
  logic [BYTE_W-1:0]     data_byte    = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [SYM_W-1:0]      symbol;
  logic                  last;
  logic                  message_done;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Local copy of the decoder state.
  logic             tree_leaf  [DEF_NODE_COUNT];
  logic [SYM_W-1:0] tree_sym   [DEF_NODE_COUNT];
  logic [IDX_W-1:0] tree_left  [DEF_NODE_COUNT];
  logic [IDX_W-1:0] tree_right [DEF_NODE_COUNT];
  logic             node_loaded[DEF_NODE_COUNT];
  logic [IDX_W-1:0] loaded_nodes[$];
  logic [IDX_W-1:0] walk_node       = '0;
  logic [IDX_W-1:0] tree_root       = '0;
  logic [COUNT_W-1:0] symbols_emitted = '0;
  logic [COUNT_W-1:0] msg_total       = '0;

  symbol_beat_t expected_symbols[$];

  int items_sent     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_percent    = 20;
  int stall_left     = 0;
  int calm_left      = 0;
  bit idle_enable    = 1'b1;

  huffman_tree_decoder_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .node_left    (node_left),
    .node_right   (node_right),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .last         (last),
    .message_done (message_done),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output stalls come in bursts, separated by calm stretches of varied length.
  always @(posedge clk) begin
    if (!idle_enable) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(1, 13);
      calm_left  <= ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin : check_symbols
    symbol_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_symbols.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected symbol beat: sym %02h last %0b done %0b",
                   symbol, last, message_done);
      end else begin
        want = expected_symbols.pop_front();
        if (symbol !== want.symbol || last !== want.last ||
            message_done !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("beat mismatch: want sym %02h last %0b done %0b, got %02h %0b %0b",
                     want.symbol, want.last, want.done, symbol, last, message_done);
        end
      end
    end
  end

  // Sends one item, waits for the beat to be taken and updates the local
  // decoder state, queueing the symbols that a data byte decodes to.
  task automatic issue_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                            input logic leaf, input logic [SYM_W-1:0] sym,
                            input logic [IDX_W-1:0] lt, input logic [IDX_W-1:0] rt,
                            input logic [BYTE_W-1:0] din);
    symbol_beat_t     produced[8];
    int               n;
    int               b;
    logic [IDX_W-1:0] next_node;
    logic             hit;
    logic [SYM_W-1:0] hit_sym;
    if (idle_enable && $urandom_range(1, 100) <= gap_percent) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    action       <= act;
    node_index   <= idx;
    node_is_leaf <= leaf;
    node_symbol  <= sym;
    node_left    <= lt;
    node_right   <= rt;
    data_byte    <= din;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
    case (act)
      ACT_LOAD: begin
        tree_leaf[idx]  = leaf;
        tree_sym[idx]   = sym;
        tree_left[idx]  = lt;
        tree_right[idx] = rt;
        if (!node_loaded[idx]) begin
          node_loaded[idx] = 1'b1;
          loaded_nodes.push_back(idx);
        end
      end
      ACT_RESTART: begin
        walk_node       = tree_root;
        symbols_emitted = '0;
      end
      ACT_DATA: begin
        n = 0;
        for (b = TOP_BIT; b >= 0; b--) begin
          if (symbols_emitted >= msg_total) break;
          hit = 1'b0;
          if (tree_leaf[walk_node]) begin
            // Standing on a leaf: this bit emits it without moving down.
            hit     = 1'b1;
            hit_sym = tree_sym[walk_node];
          end else begin
            next_node = din[b] ? tree_right[walk_node] : tree_left[walk_node];
            if (tree_leaf[next_node]) begin
              hit     = 1'b1;
              hit_sym = tree_sym[next_node];
            end else begin
              walk_node = next_node;
            end
          end
          if (hit) begin
            walk_node          = tree_root;
            symbols_emitted    = symbols_emitted + COUNT_W'(1);
            produced[n].symbol = hit_sym;
            produced[n].done   = (symbols_emitted == msg_total);
            n++;
          end
        end
        for (b = 0; b < n; b++) begin
          produced[b].last = (b == n - 1);
          expected_symbols.push_back(produced[b]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic load_node(input logic [IDX_W-1:0] idx, input logic leaf,
                           input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] lt,
                           input logic [IDX_W-1:0] rt);
    issue_item(ACT_LOAD, idx, leaf, sym, lt, rt, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] din);
    issue_item(ACT_DATA, IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
               SYM_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 511)),
               IDX_W'($urandom_range(0, 511)), din);
  endtask

  task automatic send_restart();
    issue_item(ACT_RESTART, IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
               SYM_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 511)),
               IDX_W'($urandom_range(0, 511)), BYTE_W'($urandom_range(0, 255)));
  endtask

  // Holds the input off until every symbol has come out and the last byte
  // has had time to finish, so the registers can be written safely.
  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SYMBOL_TOTAL)
      msg_total = value[COUNT_W-1:0];
    else
      tree_root = value[IDX_W-1:0];
  endtask

  // Small tree at root 0: code 0 -> 00, 10 -> A5, 11 -> FF. Some bytes end in
  // the middle of a code so the walk has to carry over to the next byte.
  task automatic test_tree_walk();
    load_node(INDEX_MAX, 1'b1, 8'hFF, INDEX_MAX, '0);
    load_node(9'd1, 1'b1, 8'h00, '0, INDEX_MAX);
    load_node(9'd2, 1'b1, 8'hA5, 9'd5, 9'd6);
    load_node(9'd3, 1'b0, 8'h00, 9'd2, INDEX_MAX);
    load_node(9'd0, 1'b0, 8'hFF, 9'd1, 9'd3);
    issue_item(ACT_UNUSED, INDEX_MAX, 1'b1, 8'hFF, INDEX_MAX, INDEX_MAX, 8'hFF);
    drain_decoder();
    write_config(CFG_SYMBOL_TOTAL, TOTAL_MAX);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h5A);
    send_data(8'h80);
    send_data(8'hC1);
    send_data(8'h7F);
  endtask

  // Zero total, a total reached in the middle of a byte, a total lowered
  // below the count, and a restart that clears the count.
  task automatic test_symbol_total();
    send_restart();
    drain_decoder();
    write_config(CFG_SYMBOL_TOTAL, '0);
    send_data(8'hFF);
    drain_decoder();
    write_config(CFG_SYMBOL_TOTAL, 24'd3);
    send_data(8'h00);
    send_data(8'h00);
    drain_decoder();
    write_config(CFG_SYMBOL_TOTAL, 24'd2);
    send_data(8'h00);
    send_restart();
    send_data(8'h00);
  endtask

  // A new root only takes hold at the next return to the root; a leaf root
  // emits one symbol per bit.
  task automatic test_root_change();
    drain_decoder();
    write_config(CFG_SYMBOL_TOTAL, TOTAL_MAX);
    write_config(CFG_ROOT_INDEX, CFG_DATA_W'(INDEX_MAX));
    send_data(8'h00);
    send_data(8'hA5);
    drain_decoder();
    write_config(CFG_ROOT_INDEX, '0);
    send_restart();
    send_data(8'h01);
  endtask

  // The walk is left on node 3, which is then rewritten as a leaf.
  task automatic test_leaf_overwrite();
    load_node(9'd3, 1'b1, 8'h3C, '0, '0);
    send_data(8'h00);
  endtask

  // Each message builds a fresh full binary tree (children before parents,
  // so any bit string decodes), points the root at it and streams random
  // bytes mixed with restarts, ignored actions and stray node loads.
  task automatic test_random_messages();
    logic [IDX_W-1:0]   subtrees[$];
    logic [IDX_W-1:0]   left_child;
    logic [IDX_W-1:0]   right_child;
    logic [IDX_W-1:0]   slot;
    logic [COUNT_W-1:0] total;
    logic               leaf_flag;
    int                 leaves;
    int                 base;
    int                 used;
    int                 pick;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_TAIL) idle_enable = 1'b0;
      case ($urandom_range(0, 2))
        0:       gap_percent = 0;
        1:       gap_percent = 15;
        default: gap_percent = 45;
      endcase
      subtrees.delete();
      leaves = $urandom_range(2, 9);
      base   = $urandom_range(0, DEF_NODE_COUNT - 1);
      used   = 0;
      repeat (leaves) begin
        slot = IDX_W'((base + used) % DEF_NODE_COUNT);
        used++;
        load_node(slot, 1'b1, SYM_W'($urandom_range(0, 255)),
                  IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)));
        subtrees.push_back(slot);
      end
      while (subtrees.size() > 1) begin
        pick       = $urandom_range(0, subtrees.size() - 1);
        left_child = subtrees[pick];
        subtrees.delete(pick);
        pick        = $urandom_range(0, subtrees.size() - 1);
        right_child = subtrees[pick];
        subtrees.delete(pick);
        slot = IDX_W'((base + used) % DEF_NODE_COUNT);
        used++;
        load_node(slot, 1'b0, SYM_W'($urandom_range(0, 255)), left_child, right_child);
        subtrees.push_back(slot);
      end
      drain_decoder();
      case ($urandom_range(0, 9))
        0:       total = '0;
        1:       total = TOTAL_MAX;
        default: total = COUNT_W'($urandom_range(1, 40));
      endcase
      write_config(CFG_SYMBOL_TOTAL, total);
      write_config(CFG_ROOT_INDEX, CFG_DATA_W'(subtrees[0]));
      if ($urandom_range(0, 4) != 0) send_restart();
      repeat ($urandom_range(8, 24)) begin
        case ($urandom_range(0, 9))
          0: send_restart();
          1: issue_item(ACT_UNUSED, IDX_W'($urandom_range(0, 511)),
                        1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                        IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)),
                        BYTE_W'($urandom_range(0, 255)));
          2: begin
            // Inner nodes only point at loaded entries, so no walk ever
            // reaches a node that was never written.
            leaf_flag = 1'($urandom_range(0, 1));
            if (leaf_flag) begin
              left_child  = IDX_W'($urandom_range(0, 511));
              right_child = IDX_W'($urandom_range(0, 511));
            end else begin
              left_child  = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
              right_child = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
            end
            load_node(IDX_W'($urandom_range(0, 511)), leaf_flag,
                      SYM_W'($urandom_range(0, 255)), left_child, right_child);
          end
          default: send_data(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    foreach (tree_leaf[i]) begin
      tree_leaf[i]   = 1'b0;
      tree_sym[i]    = '0;
      tree_left[i]   = '0;
      tree_right[i]  = '0;
      node_loaded[i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tree_walk();
    test_symbol_total();
    test_root_change();
    test_leaf_overwrite();
    test_random_messages();
    idle_enable = 1'b0;
    drain_decoder();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
